[hdl/external_interrupt_edge_controller_unit_macros.svh]
// assertion macros shared by the interrupt controller rtl
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_MACROS_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define EIEC_ASSERT_SAME(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define EIEC_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

[hdl/eiec_pkg.sv]
// types and constants of the external interrupt edge controller
package eiec_pkg;

  // fixed field widths
  localparam int LINE_W     = 16;
  localparam int SEL_W      = 4;
  localparam int PORT_CODES = 4;
  localparam int IRQ_W      = 7;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // irq grouping: lines below SINGLE_LINES get one output each
  localparam int SINGLE_LINES = 5;
  localparam int GROUP_A_LO   = 5;
  localparam int GROUP_A_HI   = 9;
  localparam int GROUP_B_LO   = 10;
  localparam int GROUP_B_HI   = 15;

  typedef enum logic [0:0] {
    MODE_SAMPLE = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    REG_PORT_SELECT    = 2'd0,
    REG_RISING_ENABLE  = 2'd1,
    REG_FALLING_ENABLE = 2'd2,
    REG_INTERRUPT_MASK = 2'd3
  } reg_idx_t;

  typedef struct packed {
    mode_t             mode;
    logic [LINE_W-1:0] port0_pins;
    logic [LINE_W-1:0] port1_pins;
    logic [LINE_W-1:0] port2_pins;
    logic [LINE_W-1:0] port3_pins;
    logic [LINE_W-1:0] clear_bits;
  } sample_item_t;

  typedef struct packed {
    logic [LINE_W-1:0] pending;
    logic [IRQ_W-1:0]  irq_lines;
    logic [LINE_W-1:0] line_levels;
  } result_item_t;

endpackage

[hdl/external_interrupt_edge_controller_unit.sv]
// top level of the 16-line external interrupt edge controller
//
//  channel  direction  signals                               transfer when
//  sample   in         sample_valid/ready, sample_item        valid && ready
//  result   out        result_valid/ready, result_item        valid && ready
//  config   in         psel penable pwrite paddr pwdata ...   psel && penable && pwrite
//
// one item per cycle sustained while the result is not stalled; an item passes through
// an input register, then edge detection and pending update into the result register.
// rst is synchronous and clears the config registers, pending, levels and valid flags.
// a stalled result holds; the input register keeps filling until it is also full.
// registers sit at byte addresses 0, 8, 16 and 24 of a 64-bit config port.
`include "external_interrupt_edge_controller_unit_macros.svh"

module external_interrupt_edge_controller_unit
  import eiec_pkg::*;
#(
  parameter int LINES = 16,
  parameter int PORTS = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  // sample channel
  input  logic                  sample_valid,
  output logic                  sample_ready,
  input  sample_item_t          sample_item,
  // result channel
  output logic                  result_valid,
  input  logic                  result_ready,
  output result_item_t          result_item,
  // config port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam logic [LINE_W-1:0] LineMask = LINE_W'((17'(1) << LINES) - 17'(1));

  // config registers
  logic [LINE_W*SEL_W-1:0] port_select;
  logic [LINE_W-1:0]       rising_enable;
  logic [LINE_W-1:0]       falling_enable;
  logic [LINE_W-1:0]       interrupt_mask;

  // controller state
  logic [LINE_W-1:0] prev_levels;
  logic [LINE_W-1:0] prev_levels_next;
  logic [LINE_W-1:0] pending_bits;
  logic [LINE_W-1:0] pending_bits_next;
  logic              primed;

  // input register and result register
  logic         s1_valid;
  sample_item_t s1_item;
  logic         advance;
  logic [LINE_W-1:0] levels;
  logic [LINE_W-1:0] out_levels;
  logic [LINE_W-1:0] req;
  logic [IRQ_W-1:0]  irq;
  logic [PORT_CODES-1:0][LINE_W-1:0] pins;
  reg_idx_t     cfg_idx;
  logic         cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign cfg_write = psel && penable && pwrite;

  // config write
  always_ff @(posedge clk) begin
    if (rst) begin
      port_select    <= '0;
      rising_enable  <= '0;
      falling_enable <= '0;
      interrupt_mask <= '0;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_PORT_SELECT:    port_select    <= pwdata;
        REG_RISING_ENABLE:  rising_enable  <= pwdata[LINE_W-1:0];
        REG_FALLING_ENABLE: falling_enable <= pwdata[LINE_W-1:0];
        REG_INTERRUPT_MASK: interrupt_mask <= pwdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  // config read
  always_comb begin
    case (cfg_idx)
      REG_PORT_SELECT:    prdata = port_select;
      REG_RISING_ENABLE:  prdata = CFG_DATA_W'(rising_enable);
      REG_FALLING_ENABLE: prdata = CFG_DATA_W'(falling_enable);
      REG_INTERRUPT_MASK: prdata = CFG_DATA_W'(interrupt_mask);
      default:            prdata = '0;
    endcase
  end

  // handshake: the input register moves on when the result register is free
  assign advance      = s1_valid && (!result_valid || result_ready);
  assign sample_ready = !s1_valid || !result_valid || result_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (sample_valid && sample_ready) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      s1_item <= sample_item;
    end
  end

  // per-line port selection
  assign pins[0] = s1_item.port0_pins;
  assign pins[1] = s1_item.port1_pins;
  assign pins[2] = s1_item.port2_pins;
  assign pins[3] = s1_item.port3_pins;

  always_comb begin
    logic [SEL_W-1:0] code;
    levels = '0;
    for (int n = 0; n < LINE_W; n++) begin
      code = port_select[n*SEL_W +: SEL_W];
      if (code < SEL_W'(PORT_CODES) && 32'(code) < PORTS) begin
        levels[n] = pins[code[1:0]][n];
      end
    end
    levels = levels & LineMask;
  end

  // edge detection and write-one-to-clear
  always_comb begin
    pending_bits_next = pending_bits;
    prev_levels_next  = prev_levels;
    out_levels        = prev_levels;
    if (s1_item.mode == MODE_SAMPLE) begin
      if (primed) begin
        pending_bits_next = pending_bits
                          | (levels & ~prev_levels & rising_enable)
                          | (~levels & prev_levels & falling_enable);
      end
      prev_levels_next = levels;
      out_levels       = levels;
    end else begin
      pending_bits_next = pending_bits & ~s1_item.clear_bits;
    end
    pending_bits_next = pending_bits_next & LineMask;
  end

  // request grouping
  always_comb begin
    req = pending_bits_next & interrupt_mask;
    irq = '0;
    irq[SINGLE_LINES-1:0] = req[SINGLE_LINES-1:0];
    irq[SINGLE_LINES]     = |req[GROUP_A_HI:GROUP_A_LO];
    irq[SINGLE_LINES+1]   = |req[GROUP_B_HI:GROUP_B_LO];
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_bits <= '0;
      prev_levels  <= '0;
      primed       <= 1'b0;
    end else if (advance) begin
      pending_bits <= pending_bits_next;
      prev_levels  <= prev_levels_next;
      if (s1_item.mode == MODE_SAMPLE) begin
        primed <= 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_item.pending     <= pending_bits_next;
      result_item.irq_lines   <= irq;
      result_item.line_levels <= out_levels;
    end
  end

  // checks
  `EIEC_ASSERT_SAME(a_pending_in_range, clk, rst, 1'b1, (pending_bits & ~LineMask) == '0, "pending bit set beyond configured lines")
  `EIEC_ASSERT_NEXT(a_no_loss_on_stall, clk, rst, s1_valid && result_valid && !result_ready, s1_valid, "held item dropped while result stalled")
  `EIEC_ASSERT_NEXT(a_clear_sets_nothing, clk, rst, advance && s1_item.mode == MODE_CLEAR, (pending_bits & ~$past(pending_bits)) == '0, "clear item raised a pending bit")
  `EIEC_ASSERT_NEXT(a_first_sample_quiet, clk, rst, advance && !primed, pending_bits == $past(pending_bits), "pending changed before first sample")

endmodule
